// File: src/lps_pkg.sv
// Package for the 3x3 edge-preserving penalty stencil.
// Holds the fixed point constants, the neighbour order and the register indexes.
// No dependencies.
package lps_pkg;

  localparam int unsigned NEIGHBOURS = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned OUT_DATA_W = 56;
  localparam int unsigned POS_W      = 11;

  // ln(2) in Q0.32, axial and diagonal weights in Q0.32
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [31:0] W_AXIAL = 32'd628983398;
  localparam logic [31:0] W_DIAG  = 32'd444758426;

  // window positions of the neighbours: four axial first, then four diagonal
  localparam logic [3:0] NB_IDX [NEIGHBOURS] = '{
    4'd1, 4'd3, 4'd5, 4'd7, 4'd0, 4'd2, 4'd6, 4'd8
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH     = 3'd0,
    CFG_LINES_PER_SLICE = 3'd1,
    CFG_SLICE_COUNT     = 3'd2,
    CFG_DELTA_VALUE     = 3'd3,
    CFG_INVERSE_DELTA   = 3'd4
  } cfg_idx_e;

endpackage

// File: src/lange_penalty_3x3_stencil.sv
// Top level of the 3x3 edge-preserving penalty stencil: line store, window,
// shared nine-stage neighbour term pipeline and output register.
// Depends on lps_pkg.
//
// A border pixel is stored but gives no result. For an interior pixel the work is
// one read-modify-write of the line store, the issue of its eight neighbour terms
// into the shared term pipeline and their passage through it; the next pixel is
// taken only once the result is in the output register. A result still waiting
// at the output holds the next pixel off.
// Reset: asynchronous, active low; afterwards a clearing pass over all MAX_LINE
// entries zeroes the line store before the first pixel is taken.
module lange_penalty_3x3_stencil #(
  parameter int unsigned MAX_LINE       = 2048,
  parameter int unsigned MAX_LINES      = 2048,
  parameter int unsigned FRAC_BITS      = 16,
  parameter int unsigned LOG_TABLE_BITS = 10
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [lps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lps_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // pixel input
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [lps_pkg::PIX_W-1:0]        s_axis_tdata,   // [31:0] pixel_value
  // result output
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [31:0] penalty_term, [42:32] centre_line, [53:43] centre_column, [55:54] zero
  output logic [lps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  output logic                             m_axis_tlast    // volume_last
);
  import lps_pkg::*;

  localparam int unsigned AW   = $clog2(MAX_LINE);
  localparam int unsigned LW   = $clog2(MAX_LINES);
  localparam int unsigned LENW = $clog2(MAX_LINE + 1);
  localparam int unsigned NLW  = $clog2(MAX_LINES + 1);
  localparam int unsigned F    = FRAC_BITS;
  localparam int unsigned L    = LOG_TABLE_BITS;
  localparam int unsigned DW   = 64 - F;          // delta^2 / 2^F
  localparam int unsigned ABW  = DW + 16;         // partial products of gamma
  localparam int unsigned PW   = DW + 33;         // full delta^2 * g
  localparam int unsigned GW   = 64 - F;          // gamma
  localparam int unsigned GHW  = GW - 32;         // upper part of gamma
  localparam int unsigned DEPTH = 9;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_READ, ST_ISSUE, ST_DRAIN, ST_OUT
  } state_e;

  // log2 mantissa table entry, evaluated at elaboration
  function automatic logic [F-1:0] log_entry(input int unsigned idx);
    logic [63:0]  y;
    logic [F-1:0] r;
    y = (64'd1 << 30) + (64'(idx) << (30 - L));
    r = '0;
    for (int b = 0; b < F; b++) begin
      y = (y * y) >> 30;
      r = {r[F-2:0], 1'b0};
      if (y >= (64'd1 << 31)) begin
        r[0] = 1'b1;
        y    = y >> 1;
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // configuration registers
  logic [11:0] cfg_len_q, cfg_nl_q;
  logic [15:0] cfg_ns_q;
  logic [31:0] delta_q, inv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_len_q <= 12'd2048;
      cfg_nl_q  <= 12'd2048;
      cfg_ns_q  <= 16'd1;
      delta_q   <= 32'd1 << F;
      inv_q     <= 32'd1 << F;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LINE_LENGTH:     cfg_len_q <= cfg_data_i[11:0];
        CFG_LINES_PER_SLICE: cfg_nl_q  <= cfg_data_i[11:0];
        CFG_SLICE_COUNT:     cfg_ns_q  <= cfg_data_i[15:0];
        CFG_DELTA_VALUE:     delta_q   <= cfg_data_i;
        CFG_INVERSE_DELTA:   inv_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // delta^2 scaled, refreshed every cycle
  logic [DW-1:0] d2q_q;
  logic [63:0]   d2_full;
  assign d2_full = 64'(delta_q) * 64'(delta_q);
  always_ff @(posedge clk_i) begin
    d2q_q <= d2_full[63:F];
  end

  // effective sizes
  logic [LENW-1:0] len_eff;
  logic [NLW-1:0]  nl_eff;
  logic [15:0]     ns_eff;
  always_comb begin
    if (32'(cfg_len_q) < 32'd3)           len_eff = LENW'(3);
    else if (32'(cfg_len_q) > MAX_LINE)   len_eff = LENW'(MAX_LINE);
    else                                  len_eff = LENW'(cfg_len_q);
    if (32'(cfg_nl_q) < 32'd3)            nl_eff  = NLW'(3);
    else if (32'(cfg_nl_q) > MAX_LINES)   nl_eff  = NLW'(MAX_LINES);
    else                                  nl_eff  = NLW'(cfg_nl_q);
    ns_eff = (cfg_ns_q == 16'd0) ? 16'd1 : cfg_ns_q;
  end

  // ---------------------------------------------------------------------------
  // position counters
  logic [AW-1:0] col_q;
  logic [LW-1:0] line_q;
  logic [15:0]   slice_q;
  logic          col_end, line_end, slice_end, emit, last;
  logic          in_acc;
  state_e        state_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign col_end   = (LENW'(col_q) + LENW'(1)) >= len_eff;
  assign line_end  = (NLW'(line_q) + NLW'(1)) >= nl_eff;
  assign slice_end = (17'(slice_q) + 17'd1) >= 17'(ns_eff);
  assign emit      = (32'(line_q) >= 32'd2) && (32'(col_q) >= 32'd2);
  assign last      = slice_end && line_end && col_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      line_q  <= '0;
      slice_q <= '0;
    end else if (in_acc) begin
      if (col_end) begin
        col_q <= '0;
        if (line_end) begin
          line_q  <= '0;
          slice_q <= slice_end ? 16'd0 : slice_q + 16'd1;
        end else begin
          line_q <= line_q + LW'(1);
        end
      end else begin
        col_q <= col_q + AW'(1);
      end
    end
  end

  // per-item payload captured at acceptance
  logic [31:0]      pix_q;
  logic [AW-1:0]    addr_q;
  logic             emit_q, last_q;
  logic [POS_W-1:0] pos_line_q, pos_col_q;
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      pix_q      <= s_axis_tdata;
      addr_q     <= col_q;
      emit_q     <= emit;
      last_q     <= last;
      pos_line_q <= POS_W'(32'(line_q) - 32'd1);
      pos_col_q  <= POS_W'(32'(col_q) - 32'd1);
    end
  end

  // ---------------------------------------------------------------------------
  // line store: {line before previous, previous line} per column
  logic [63:0]   mem [MAX_LINE];
  logic [63:0]   rd_q;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [63:0]   mem_wd;
  logic [AW-1:0] clr_q;

  always_comb begin
    mem_we = 1'b0;
    mem_wa = addr_q;
    mem_wd = {rd_q[31:0], pix_q};
    if (state_q == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_q;
      mem_wd = '0;
    end else if (state_q == ST_READ) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[col_q];
  end

  // 3x3 window, row 0 oldest line, column 2 newest
  logic [31:0] win_q [9];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 9; i++) win_q[i] <= '0;
    end else if (state_q == ST_READ) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r*3]     <= win_q[r*3 + 1];
        win_q[r*3 + 1] <= win_q[r*3 + 2];
      end
      win_q[2] <= rd_q[63:32];
      win_q[5] <= rd_q[31:0];
      win_q[8] <= pix_q;
    end
  end

  // ---------------------------------------------------------------------------
  // neighbour term pipeline
  logic [2:0]       issue_q;
  logic [DEPTH-1:0] v_q;
  logic [DEPTH-1:0] ax_q;
  logic             iv;
  logic [31:0]      nb;

  assign iv = (state_q == ST_ISSUE);
  assign nb = win_q[NB_IDX[issue_q]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DEPTH-2:0], iv};
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= {ax_q[DEPTH-2:0], (issue_q < 3'd4)};
  end

  // S1: absolute difference
  logic [32:0] diff;
  logic [31:0] ad1_q;
  assign diff = {win_q[4][31], win_q[4]} - {nb[31], nb};
  always_ff @(posedge clk_i) begin
    ad1_q <= diff[32] ? 32'(-diff) : diff[31:0];
  end

  // S2: m = |d| / delta, saturating
  logic [63:0] mprod;
  logic [31:0] m2_q;
  assign mprod = 64'(ad1_q) * 64'(inv_q);
  always_ff @(posedge clk_i) begin
    m2_q <= (|mprod[63:32+F]) ? 32'hFFFF_FFFF : mprod[32+F-1:F];
  end

  // S3: x = 1 + m and its leading one
  logic [32:0] x3;
  logic [5:0]  e3;
  logic [32:0] x3_q;
  logic [5:0]  e3_q;
  logic [31:0] m3_q;
  assign x3 = {1'b0, m2_q} + (33'd1 << F);
  always_comb begin
    e3 = '0;
    for (int i = 0; i < 33; i++) begin
      if (x3[i]) e3 = 6'(i);
    end
  end
  always_ff @(posedge clk_i) begin
    x3_q <= x3;
    e3_q <= e3;
    m3_q <= m2_q;
  end

  // S4: mantissa index and table read
  logic [F-1:0]    log_rom [2**L];
  logic [33+L-1:0] xsh;
  logic [L-1:0]    lidx;
  logic [F-1:0]    log4_q;
  logic [5:0]      e4_q;
  logic [31:0]     m4_q;
  for (genvar gi = 0; gi < 2**L; gi++) begin : g_rom
    assign log_rom[gi] = log_entry(gi);
  end
  assign xsh  = {x3_q, {L{1'b0}}} >> e3_q;
  assign lidx = xsh[L-1:0];
  always_ff @(posedge clk_i) begin
    log4_q <= log_rom[lidx];
    e4_q   <= e3_q;
    m4_q   <= m3_q;
  end

  // S5: ln(1 + m)
  logic [31:0] lg;
  logic [63:0] lnprod;
  logic [31:0] ln5_q, m5_q;
  assign lg     = ((32'(e4_q) - 32'(F)) << F) + 32'(log4_q);
  assign lnprod = 64'(lg) * 64'(LN2_Q32);
  always_ff @(posedge clk_i) begin
    ln5_q <= lnprod[63:32];
    m5_q  <= m4_q;
  end

  // S6: g = m - ln, partial products with delta^2
  logic [31:0]    g6;
  logic [ABW-1:0] a6_q, b6_q;
  assign g6 = (ln5_q > m5_q) ? 32'd0 : (m5_q - ln5_q);
  always_ff @(posedge clk_i) begin
    a6_q <= ABW'(d2q_q) * ABW'(g6[15:0]);
    b6_q <= ABW'(d2q_q) * ABW'(g6[31:16]);
  end

  // S7: combine, saturate at 64 bits, scale
  logic [PW-1:0] p7;
  logic [GW-1:0] gam7_q;
  assign p7 = PW'(a6_q) + (PW'(b6_q) << 16);
  always_ff @(posedge clk_i) begin
    gam7_q <= (|p7[PW-1:64]) ? {GW{1'b1}} : p7[63:F];
  end

  // S8: weight products
  logic [31:0]      w8;
  logic [GHW+31:0]  hi8_q;
  logic [63:0]      lo8_q;
  assign w8 = ax_q[6] ? W_AXIAL : W_DIAG;
  always_ff @(posedge clk_i) begin
    hi8_q <= (GHW+32)'(gam7_q[GW-1:32]) * (GHW+32)'(w8);
    lo8_q <= 64'(gam7_q[31:0]) * 64'(w8);
  end

  // S9: term, clipped to 32 bits
  logic [GHW+32:0] part9;
  logic [31:0]     part9_q;
  assign part9 = (GHW+33)'(hi8_q) + (GHW+33)'(lo8_q[63:32]);
  always_ff @(posedge clk_i) begin
    part9_q <= (|part9[GHW+32:32]) ? 32'hFFFF_FFFF : part9[31:0];
  end

  // ---------------------------------------------------------------------------
  // sequencer, accumulator and output register
  logic [34:0] acc_q;
  logic [3:0]  done_q;
  logic [31:0] pen_q;
  logic [POS_W-1:0] out_line_q, out_col_q;
  logic        out_last_q, out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      issue_q     <= '0;
      done_q      <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      pen_q       <= '0;
      out_line_q  <= '0;
      out_col_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // the output state handles its own valid
      if (out_valid_q && m_axis_tready && state_q != ST_OUT) out_valid_q <= 1'b0;
      if (v_q[DEPTH-1]) begin
        acc_q  <= acc_q + 35'(part9_q);
        done_q <= done_q + 4'd1;
      end
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_LINE - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (in_acc) state_q <= ST_READ;
        end
        ST_READ: begin
          issue_q <= '0;
          done_q  <= '0;
          acc_q   <= '0;
          state_q <= emit_q ? ST_ISSUE : ST_IDLE;
        end
        ST_ISSUE: begin
          issue_q <= issue_q + 3'd1;
          if (issue_q == 3'(NEIGHBOURS - 1)) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (done_q == 4'(NEIGHBOURS)) state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q <= 1'b1;
            pen_q       <= (|acc_q[34:32]) ? 32'hFFFF_FFFF : acc_q[31:0];
            out_line_q  <= pos_line_q;
            out_col_q   <= pos_col_q;
            out_last_q  <= last_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_col_q, out_line_q, pen_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // assertions
  a_done_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q <= 4'(NEIGHBOURS))
    else $error("more neighbour terms than neighbours");

  a_term_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DEPTH-1] |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("term left the pipeline outside an interior pixel");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_OUT)
    else $error("result raised outside the output state");

endmodule

// File: bench/tb.sv
// Self-checking bench for the 3x3 edge-preserving penalty stencil.
// Streams small volumes in raster order and checks every result against an in-bench predictor.
// Depends on lps_pkg and lange_penalty_3x3_stencil.
module tb;
  import lps_pkg::*;

  localparam int unsigned MAXL    = 2048;
  localparam int unsigned FRAC    = 16;
  localparam int unsigned LOGB    = 10;
  localparam longint unsigned M32 = 64'hFFFF_FFFF;
  localparam int unsigned RANDOM_ITEMS = 900;

  typedef struct packed {
    logic [31:0] penalty;
    logic [10:0] line;
    logic [10:0] column;
    logic        last;
  } penalty_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [PIX_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic m_axis_tlast;

  lange_penalty_3x3_stencil i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // predictor state
  logic [31:0] log_tab [1 << LOGB];
  logic [31:0] pix_lines [2 * MAXL];
  logic [31:0] win [9];
  int unsigned col_cnt, line_cnt, slice_cnt;
  logic [11:0] cfg_len, cfg_lines;
  logic [15:0] cfg_slices;
  logic [31:0] cfg_delta, cfg_inv;

  penalty_res_t expected_q [$];
  int unsigned  fail_count = 0;
  int unsigned  pixels_sent = 0;
  int unsigned  results_seen = 0;
  bit           calm = 1'b0;
  int unsigned  hold_req = 0;
  int unsigned  hold_seen = 0;
  int unsigned  hold_left = 0;

  // mantissa log2 table by repeated squaring
  function automatic logic [31:0] log_entry(int unsigned idx);
    longint unsigned y, r;
    y = (64'd1 << 30) + (longint'(idx) << (30 - LOGB));
    r = 0;
    for (int b = 0; b < FRAC; b++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= (64'd1 << 31)) begin
        r = r | 1;
        y = y >> 1;
      end
    end
    return r[31:0];
  endfunction

  function automatic longint unsigned ln_fixed(longint unsigned m);
    longint unsigned x, lg;
    int e;
    int unsigned idx;
    x = (64'd1 << FRAC) + m;
    e = 63;
    while (e > 0 && x[e] == 1'b0) e--;
    if (e >= LOGB) idx = 32'((x >> (e - LOGB)) & ((1 << LOGB) - 1));
    else idx = 32'((x << (LOGB - e)) & ((1 << LOGB) - 1));
    lg = (longint'(e - FRAC) << FRAC) + log_tab[idx];
    return (lg * LN2_Q32) >> 32;
  endfunction

  function automatic longint unsigned pair_penalty(logic [31:0] ctr, logic [31:0] nb,
                                                   longint unsigned w);
    longint d;
    longint unsigned ad, m, ln, g, d2q, p, gam, part;
    logic [127:0] wide;
    d = longint'($signed(ctr)) - longint'($signed(nb));
    ad = (d < 0) ? -d : d;
    m = (ad * longint'(cfg_inv)) >> FRAC;
    if (m > M32) m = M32;
    ln = ln_fixed(m);
    g = (ln > m) ? 0 : m - ln;
    d2q = (longint'(cfg_delta) * longint'(cfg_delta)) >> FRAC;
    wide = {64'd0, d2q} * {64'd0, g};
    p = (wide[127:64] != 0) ? 64'hFFFF_FFFF_FFFF_FFFF : wide[63:0];
    gam = p >> FRAC;
    part = (gam >> 32) * w + (((gam & M32) * w) >> 32);
    return (part > M32) ? M32 : part;
  endfunction

  // advance the predictor by one accepted pixel
  task automatic predict_pixel(logic [31:0] u);
    int unsigned len, nl, ns, c;
    logic [31:0] top, mid;
    longint unsigned acc;
    bit last;
    penalty_res_t r;
    len = (cfg_len < 3) ? 3 : (cfg_len > MAXL) ? MAXL : cfg_len;
    nl = (cfg_lines < 3) ? 3 : (cfg_lines > MAXL) ? MAXL : cfg_lines;
    ns = (cfg_slices == 0) ? 1 : cfg_slices;
    c = (col_cnt >= MAXL) ? 0 : col_cnt;
    top = pix_lines[MAXL + c];
    mid = pix_lines[c];
    pix_lines[MAXL + c] = mid;
    pix_lines[c] = u;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = top;
    win[5] = mid;
    win[8] = u;
    last = (slice_cnt + 1 >= ns) && (line_cnt + 1 >= nl) && (c + 1 >= len);
    if (line_cnt >= 2 && c >= 2) begin
      acc = 0;
      for (int q = 0; q < NEIGHBOURS; q++)
        acc += pair_penalty(win[4], win[NB_IDX[q]], (q < 4) ? W_AXIAL : W_DIAG);
      r.penalty = (acc > M32) ? 32'hFFFF_FFFF : acc[31:0];
      r.line = 11'(line_cnt - 1);
      r.column = 11'(c - 1);
      r.last = last;
      expected_q.push_back(r);
    end
    if (c + 1 >= len) begin
      col_cnt = 0;
      if (line_cnt + 1 >= nl) begin
        line_cnt = 0;
        slice_cnt = (slice_cnt + 1 >= ns) ? 0 : slice_cnt + 1;
      end else begin
        line_cnt++;
      end
    end else begin
      col_cnt = c + 1;
    end
  endtask

  // one pixel transaction; valid is only lowered during an idle gap
  task automatic send_pixel(logic [31:0] v);
    while (!calm && $urandom_range(99) < 26) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= v;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_pixel(v);
    pixels_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_LINE_LENGTH:     cfg_len = val[11:0];
      CFG_LINES_PER_SLICE: cfg_lines = val[11:0];
      CFG_SLICE_COUNT:     cfg_slices = val[15:0];
      CFG_DELTA_VALUE:     cfg_delta = val;
      CFG_INVERSE_DELTA:   cfg_inv = val;
      default: ;
    endcase
  endtask

  task automatic set_volume(logic [31:0] len, logic [31:0] nl, logic [31:0] ns);
    write_reg(CFG_LINE_LENGTH, len);
    write_reg(CFG_LINES_PER_SLICE, nl);
    write_reg(CFG_SLICE_COUNT, ns);
  endtask

  task automatic set_delta(logic [31:0] dv, logic [31:0] inv);
    write_reg(CFG_DELTA_VALUE, dv);
    write_reg(CFG_INVERSE_DELTA, inv);
  endtask

  // mostly values near a base so the log path sees small and mid m
  function automatic logic [31:0] pick_pixel(logic [31:0] base);
    int unsigned sh;
    case ($urandom_range(9))
      0, 1: return $urandom;
      2: return ($urandom_range(1)) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        sh = $urandom_range(22);
        return base + ($urandom & ((32'd1 << sh) - 1)) - (32'd1 << sh) / 2;
      end
    endcase
  endfunction

  task automatic send_pixels(int unsigned n);
    logic [31:0] base;
    base = $urandom;
    repeat (n) send_pixel(pick_pixel(base));
  endtask

  // result checker, sampled at the rising edge
  always @(posedge clk_i) begin
    penalty_res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result transaction %h", m_axis_tdata);
        fail_count++;
      end else begin
        e = expected_q.pop_front();
        if (m_axis_tdata[31:0] !== e.penalty) begin
          $error("penalty_term exp %h got %h", e.penalty, m_axis_tdata[31:0]);
          fail_count++;
        end
        if (m_axis_tdata[42:32] !== e.line) begin
          $error("centre_line exp %0d got %0d", e.line, m_axis_tdata[42:32]);
          fail_count++;
        end
        if (m_axis_tdata[53:43] !== e.column) begin
          $error("centre_column exp %0d got %0d", e.column, m_axis_tdata[53:43]);
          fail_count++;
        end
        if (m_axis_tlast !== e.last) begin
          $error("volume_last exp %0d got %0d", e.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  // receiver ready: random stalls, plus a long counted hold on request
  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = 400;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(99) >= 26);
    end
  end

  // extremes of the pixel range and both signs
  task automatic test_directed_extremes();
    logic [31:0] vals [16] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                               32'h0001_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'hFFFF_0000, 32'h0000_0001, 32'h1234_5678, 32'h0,
                               32'h8000_0001, 32'h7FFF_FFFE, 32'h0, 32'hFFFF_FFFF};
    set_volume(4, 4, 1);
    set_delta(32'h0001_0000, 32'h0001_0000);
    foreach (vals[k]) send_pixel(vals[k]);
    drain();
  endtask

  // sizes below range clamp to 3, zero slices act as one
  task automatic test_size_clamp();
    set_volume(0, 1, 0);
    send_pixels(9);
    drain();
    set_volume(2, 4095, 65535);
    send_pixels(12);
    drain();
  endtask

  // delta of zero and all-ones scale values
  task automatic test_delta_extremes();
    set_volume(3, 3, 1);
    set_delta(0, 32'h0001_0000);
    send_pixels(9);
    drain();
    set_delta(32'hFFFF_FFFF, 1);
    send_pixels(9);
    drain();
    set_delta(32'h0000_0100, 32'hFFFF_FFFF);
    send_pixels(9);
    drain();
    set_delta(1, 32'h0001_0000);
    send_pixels(9);
    drain();
  endtask

  // over-range length clamps to the maximum; part of one long line, cut short
  task automatic test_longest_line();
    set_volume(4095, 3, 1);
    set_delta(32'h0002_0000, 32'h0000_8000);
    calm = 1'b1;
    send_pixels(300);
    drain();
    calm = 1'b0;
  endtask

  // receiver holds off while pixels keep coming
  task automatic test_backpressure();
    set_volume(6, 5, 2);
    set_delta(32'h0000_8000, 32'h0002_0000);
    hold_req++;
    send_pixels(60);
    drain();
  endtask

  // random volumes, mostly whole, some cut short
  task automatic test_random_volumes();
    int unsigned sent, len, nl, ns, n;
    logic [31:0] dv;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(3, 10);
      nl = $urandom_range(3, 7);
      ns = $urandom_range(1, 3);
      if ($urandom_range(9) == 0) set_volume($urandom_range(0, 2), nl, ns);
      else set_volume(len, nl, ns);
      dv = $urandom_range(32'h0000_1000, 32'h0010_0000);
      if ($urandom_range(4) == 0) set_delta($urandom, $urandom);
      else set_delta(dv, 32'(64'h1_0000_0000 / dv));
      calm = ($urandom_range(7) == 0);
      n = (cfg_len < 3 ? 3 : cfg_len) * nl * ns;
      if ($urandom_range(9) == 0) n = $urandom_range(1, n);
      send_pixels(n);
      sent += n;
      drain();
      calm = 1'b0;
    end
  endtask

  initial begin
    #(8 * 3_000_000);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    for (int k = 0; k < (1 << LOGB); k++) log_tab[k] = log_entry(k);
    foreach (pix_lines[k]) pix_lines[k] = '0;
    foreach (win[k]) win[k] = '0;
    col_cnt = 0;
    line_cnt = 0;
    slice_cnt = 0;
    cfg_len = 2048;
    cfg_lines = 2048;
    cfg_slices = 1;
    cfg_delta = 32'h0001_0000;
    cfg_inv = 32'h0001_0000;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_extremes();
    test_size_clamp();
    test_delta_extremes();
    test_longest_line();
    test_backpressure();
    test_random_volumes();
    drain();
    $display("Covered %0d pixel transactions and %0d result transactions", pixels_sent,
             results_seen);
    $display("over clamped, extreme-delta, long-line, stalled and random volumes.");
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
